@@ rtl/core/tba_pkg.sv @@
package tba_pkg;

    // Configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam int CFG_W = 9;

    // Result status codes
    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] tile_number;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_tile;
        logic [7:0] tile_column;
        logic [7:0] tile_row;
    } t_rsp;

endpackage

@@ rtl/core/tile_block_allocator_unit.sv @@
// First-fit tile allocator for an atlas grid of equal tiles.
//
// Request channel: drive i_req and raise start; the transaction is taken
// at a rising edge where start is high and busy is low. An allocate claims
// the lowest free tile below columns * rows (capped at MAX_TILES) and
// returns its number, column and row; a free clears an in-range tile's bit.
// Result channel: o_rsp is shown for one cycle with o_done high. The
// receiver cannot hold results off, so there is no back-pressure.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 columns, 1 rows) at once; write only while busy is low.
// Sequencing: a free passes through the prep, wait and free states before
// o_done. An allocate scans the used store one 32-tile row at a time (a
// memory read in wait, a check in scan); on a hit a bit-serial divider
// then yields the row and column.
// One transaction is worked on at a time; busy stays high meanwhile.
// Reset: a clearing pass writes every row of the used store to zero with
// busy high; registers return to 16 x 16.
module tile_block_allocator_unit #(
    parameter int MAX_TILES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tba_pkg::t_req                 i_req,
    output logic                          o_done,
    output tba_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [tba_pkg::CFG_W-1:0]     i_cfg_data
);
    import tba_pkg::*;

    localparam int WORD_W  = 32;
    localparam int WORDS   = (MAX_TILES + WORD_W - 1) / WORD_W;
    localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TILE_W  = $clog2(MAX_TILES);
    localparam int CNT_W   = $clog2(MAX_TILES + 1);
    localparam int VAL_W   = ((CNT_W > 8) ? CNT_W : 8) + 2;
    localparam int BIT_W   = (TILE_W > 1) ? $clog2(TILE_W) : 1;
    localparam int PROD_W  = 2 * CFG_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CFG_W-1:0]   r_cols, r_rows;
    t_req               r_req;
    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_addr;
    logic [WORD_W-1:0]  r_mem [WORDS];
    logic [WORD_W-1:0]  r_rdata;
    logic [TILE_W-1:0]  r_tile;
    logic [TILE_W-1:0]  r_quo;
    logic [CFG_W:0]     r_rem;
    logic [BIT_W-1:0]   r_bit;
    logic               r_done;
    t_rsp               r_rsp;

    logic               mem_we;
    logic [WORD_W-1:0]  mem_wdata;

    // Tile count: product capped at MAX_TILES
    logic [PROD_W-1:0]  prod;
    logic [CNT_W-1:0]   cap_count;

    // Scan view of the current row
    logic [VAL_W-1:0]   base;
    logic [VAL_W-1:0]   remain;
    logic [VAL_W-1:0]   tile_wide;
    logic [WORD_W-1:0]  free_bits;
    logic               hit;
    logic [4:0]         hit_idx;
    logic               last_row;
    logic               in_range;

    // Divider step
    logic [CFG_W:0]     rem_sh;
    logic               rem_ge;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    always_comb begin
        prod = PROD_W'(r_cols) * PROD_W'(r_rows);
        if (prod > PROD_W'(MAX_TILES)) begin
            cap_count = CNT_W'(MAX_TILES);
        end else begin
            cap_count = prod[CNT_W-1:0];
        end
    end

    assign base      = VAL_W'(r_addr) << 5;
    assign remain    = (VAL_W'(r_count) > base) ? (VAL_W'(r_count) - base) : '0;
    assign last_row  = (base + VAL_W'(WORD_W)) >= VAL_W'(r_count);
    assign tile_wide = VAL_W'(r_req.tile_number);
    assign in_range  = tile_wide < VAL_W'(r_count);

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            free_bits[b] = !r_rdata[b] && (VAL_W'(b) < remain);
        end
    end

    // Lowest free bit of the row
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit     = 1'b1;
                hit_idx = 5'(b);
            end
        end
    end

    assign rem_sh = {r_rem[CFG_W-1:0], r_tile[r_bit]};
    assign rem_ge = rem_sh >= {1'b0, r_cols};

    // Used-store write port
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rdata;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_SCAN: begin
                mem_we = hit;
                mem_wdata[hit_idx] = 1'b1;
            end
            S_FREE: begin
                mem_we = in_range;
                mem_wdata[r_req.tile_number[4:0]] = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_addr == ADDR_W'(WORDS - 1)) n_state = S_IDLE;
            S_IDLE:  if (start) n_state = S_PREP;
            S_PREP:  n_state = S_WAIT;
            S_WAIT:  n_state = (r_req.action == ACT_FREE) ? S_FREE : S_SCAN;
            S_SCAN: begin
                if (hit) begin
                    n_state = S_DIV;
                end else if (last_row) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_FREE:  n_state = S_IDLE;
            S_DIV:   if (r_bit == '0) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_cols  <= CFG_W'(16);
            r_rows  <= CFG_W'(16);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COLUMNS) begin
                    r_cols <= i_cfg_data;
                end else begin
                    r_rows <= i_cfg_data;
                end
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                end
                S_IDLE: begin
                    r_req <= i_req;
                end
                S_PREP: begin
                    r_count <= cap_count;
                    // Free addresses its own row; allocate starts at row zero
                    if (r_req.action == ACT_FREE) begin
                        r_addr <= ADDR_W'(tile_wide >> 5);
                    end else begin
                        r_addr <= '0;
                    end
                end
                S_WAIT: begin
                    r_addr <= r_addr;
                end
                S_SCAN: begin
                    if (hit) begin
                        r_tile <= TILE_W'(base + VAL_W'(hit_idx));
                        r_quo  <= '0;
                        r_rem  <= '0;
                        r_bit  <= BIT_W'(TILE_W - 1);
                    end else if (last_row) begin
                        r_done <= 1'b1;
                        r_rsp  <= '{status: ST_FULL, granted_tile: 8'd0,
                                    tile_column: 8'd0, tile_row: 8'd0};
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                S_FREE: begin
                    r_done <= 1'b1;
                    r_rsp  <= '{status: (in_range ? ST_FREED : ST_RANGE),
                                granted_tile: 8'd0, tile_column: 8'd0, tile_row: 8'd0};
                end
                S_DIV: begin
                    // One restoring-division step per cycle, MSB first
                    r_quo[r_bit] <= rem_ge;
                    r_rem        <= rem_ge ? (rem_sh - {1'b0, r_cols}) : rem_sh;
                    if (r_bit == '0) begin
                        r_done                   <= 1'b1;
                        r_rsp.status             <= ST_GRANTED;
                        r_rsp.granted_tile       <= 8'(16'(r_tile));
                        r_rsp.tile_column        <= rem_ge ? 8'(rem_sh - {1'b0, r_cols})
                                                           : 8'(rem_sh);
                        r_rsp.tile_row           <= 8'(16'({r_quo[TILE_W-1:1], rem_ge}));
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                default: begin
                    r_addr <= r_addr;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // No result may appear while the used store is being cleared
    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result strobe during clearing pass");

    // A freshly accepted transaction cannot answer in the next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result one cycle after accept");

    // Non-grant results carry zero tile fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_GRANTED) |->
        (o_rsp.granted_tile == 8'd0 && o_rsp.tile_column == 8'd0 && o_rsp.tile_row == 8'd0))
        else $error("non-grant result with tile fields set");

    // A granted column always lies inside the grid width
    a_column_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_GRANTED) |-> ({1'b0, o_rsp.tile_column} < r_cols))
        else $error("granted column outside grid");
`endif

endmodule
